### sv/tbpf_pkg.sv
// Shared types and constants for the tile background pixel fetch block.
// No dependencies.
package tbpf_pkg;

    // Video RAM geometry: 16 KB seen as 4 byte lanes of 4096 words.
    localparam int VRAM_BYTES  = 16384;
    localparam int VRAM_LANES  = 4;
    localparam int VRAM_WORDS  = VRAM_BYTES / VRAM_LANES;
    localparam int WADDR_W     = $clog2(VRAM_WORDS);

    localparam int PIXEL_W     = 6;
    localparam int CFG_IDX_W   = 3;

    // Vertical wrap of the scrolled line.
    localparam logic [8:0] LINE_WRAP   = 9'd224;
    localparam logic [8:0] LINE_WRAP2  = 9'd448;
    // Source column from which the vertical lock applies (24 * 8).
    localparam logic [8:0] VLOCK_X     = 9'd192;
    localparam logic [7:0] HLOCK_LINES = 8'd16;
    localparam logic [7:0] LEFT_COL_W  = 8'd8;
    localparam logic [8:0] HSCROLL_TOP = 9'd256;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_PIXEL = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE_CONTROL    = 3'd0,
        REG_DISPLAY_CONTROL = 3'd1,
        REG_NAME_TABLE      = 3'd2,
        REG_BACKDROP        = 3'd3,
        REG_SCROLL_X        = 3'd4,
        REG_SCROLL_Y        = 3'd5,
        REG_HANDHELD_MODE   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] mode_control;
        logic [7:0] display_control;
        logic [7:0] name_table;
        logic [7:0] backdrop;
        logic [7:0] scroll_x;
        logic [7:0] scroll_y;
        logic       handheld;
    } cfg_t;

    // Context of a pixel while its name table word is read.
    typedef struct packed {
        logic       half;      // upper 16 bits of the word hold the entry
        logic [2:0] row;
        logic [2:0] fx;
        logic       bd;        // result is the backdrop
        logic [5:0] bd_pix;
    } s2_t;

    // Context of a pixel while its pattern row is read.
    typedef struct packed {
        logic [2:0] fx;
        logic [1:0] pal_pri;
        logic       bd;
        logic [5:0] bd_pix;
    } s3_t;

endpackage

### sv/tbpf_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module tbpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/tbpf_cfg_regs.sv
// Configuration register file of the background fetch block.
// Depends on tbpf_pkg.
module tbpf_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tbpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    output tbpf_pkg::cfg_t                 cfg
);

    tbpf_pkg::cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (tbpf_pkg::reg_idx_t'(cfg_index))
                tbpf_pkg::REG_MODE_CONTROL:    cfg_next.mode_control    = cfg_data;
                tbpf_pkg::REG_DISPLAY_CONTROL: cfg_next.display_control = cfg_data;
                tbpf_pkg::REG_NAME_TABLE:      cfg_next.name_table      = cfg_data;
                tbpf_pkg::REG_BACKDROP:        cfg_next.backdrop        = cfg_data;
                tbpf_pkg::REG_SCROLL_X:        cfg_next.scroll_x        = cfg_data;
                tbpf_pkg::REG_SCROLL_Y:        cfg_next.scroll_y        = cfg_data;
                tbpf_pkg::REG_HANDHELD_MODE:   cfg_next.handheld        = cfg_data[0];
                default: ;  // unused index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode_control    <= 8'd0;
            cfg_reg.display_control <= 8'd0;
            cfg_reg.name_table      <= 8'hFF;
            cfg_reg.backdrop        <= 8'd0;
            cfg_reg.scroll_x        <= 8'd0;
            cfg_reg.scroll_y        <= 8'd0;
            cfg_reg.handheld        <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/tbpf_out_queue.sv
// Result queue between the fetch pipeline and the output channel.
// No dependencies.
module tbpf_out_queue #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/tile_background_pixel_fetch_core.sv
// Tile background pixel fetch: byte writes into a 16 KB video RAM, pixel lookups from it.
// A pixel result passes the stage 2 and stage 3 registers, then the output queue.
// After a pixel, no item is taken until its pattern row is read (name table read, then
// pattern row read on the one video RAM port); a write every cycle while s_ready is high.
// Reset: synchronous, active low; then a clearing pass zeroes all 4096 video RAM words
// (no items accepted meanwhile, configuration writes still taken). Depends on tbpf_pkg.
module tile_background_pixel_fetch_core #(
    parameter int OUT_DEPTH = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tbpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    // input items
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_mode,
    input  logic [13:0]                    s_ram_address,
    input  logic [7:0]                     s_ram_data,
    input  logic [7:0]                     s_line,
    input  logic [7:0]                     s_pixel_x,
    // result items
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [5:0]                     m_pixel
);

    localparam int WADDR_W = tbpf_pkg::WADDR_W;
    localparam int LANES   = tbpf_pkg::VRAM_LANES;
    localparam int PEND_W  = $clog2(OUT_DEPTH + 1);

    tbpf_pkg::cfg_t cfg;

    tbpf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic               clr_active_reg, clr_active_next;
    logic [WADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic               s2_valid_reg, s3_valid_reg;
    tbpf_pkg::s2_t      s2_reg, s2_next;
    tbpf_pkg::s3_t      s3_reg, s3_next;
    // pixel items accepted whose results have not left the output channel
    logic [PEND_W-1:0]  pend_reg, pend_next;

    logic in_acc, acc_write, acc_pixel, out_pop;

    // The RAM port is held by the pattern read whenever stage 2 is busy, and a
    // pixel is only taken if the output queue is sure to have room for it.
    assign s_ready   = !clr_active_reg && !s2_valid_reg && (pend_reg < PEND_W'(OUT_DEPTH));
    assign in_acc    = s_valid && s_ready;
    assign acc_write = in_acc && (s_mode == tbpf_pkg::OP_WRITE);
    assign acc_pixel = in_acc && (s_mode == tbpf_pkg::OP_PIXEL);
    assign out_pop   = m_valid && m_ready;

    // ------------------------------------------------------------------
    // Stage 1: scroll, lock and name table address for the incoming item
    // ------------------------------------------------------------------
    logic [8:0]         ysum, hscroll, total, lock_col;
    logic [7:0]         vline;
    logic               hlock, vlock, bd;
    logic [2:0]         row;
    logic [4:0]         ntrow, tcol;
    logic [WADDR_W-1:0] nt_waddr;

    always_comb begin
        ysum = {1'b0, s_line} + {1'b0, cfg.scroll_y};
        priority if (ysum >= tbpf_pkg::LINE_WRAP2) begin
            vline = 8'(ysum - tbpf_pkg::LINE_WRAP2);
        end else if (ysum >= tbpf_pkg::LINE_WRAP) begin
            vline = 8'(ysum - tbpf_pkg::LINE_WRAP);
        end else begin
            vline = ysum[7:0];
        end

        // top lines can be held unscrolled horizontally
        hlock   = !cfg.handheld && cfg.mode_control[6] && (s_line < tbpf_pkg::HLOCK_LINES);
        hscroll = hlock ? 9'd0 : tbpf_pkg::HSCROLL_TOP - {1'b0, cfg.scroll_x};

        // right-hand columns can be held unscrolled vertically
        lock_col = {1'b0, s_pixel_x} + {6'd0, hscroll[2:0]};
        vlock    = !cfg.handheld && cfg.mode_control[7] && (lock_col >= tbpf_pkg::VLOCK_X);

        row   = vlock ? s_line[2:0] : vline[2:0];
        ntrow = vlock ? s_line[7:3] : vline[7:3];

        total = {1'b0, s_pixel_x} + hscroll;
        tcol  = total[7:3];   // wraps mod 32 columns

        // base, row and column fields do not overlap: the address is a concatenation
        nt_waddr = {cfg.name_table[3:1], ntrow, tcol[4:1]};

        bd = !cfg.display_control[6]
           || (!cfg.handheld && !cfg.name_table[0])
           || (cfg.mode_control[5] && (s_pixel_x < tbpf_pkg::LEFT_COL_W));

        s2_next.half   = tcol[0];
        s2_next.row    = row;
        s2_next.fx     = total[2:0];
        s2_next.bd     = bd;
        s2_next.bd_pix = {2'b01, cfg.backdrop[3:0]};
    end

    // ------------------------------------------------------------------
    // Video RAM: four byte lanes sharing one word address
    // ------------------------------------------------------------------
    logic [7:0]         lane_rd [LANES];
    logic [WADDR_W-1:0] ram_addr, pat_waddr;
    logic [15:0]        attr;
    logic [2:0]         row_f;

    // Stage 2: name table entry is on the read data; flips and pattern address.
    always_comb begin
        attr  = s2_reg.half ? {lane_rd[3], lane_rd[2]} : {lane_rd[1], lane_rd[0]};
        row_f = attr[10] ? ~s2_reg.row : s2_reg.row;
        pat_waddr = {attr[8:0], row_f};

        s3_next.fx      = attr[9] ? ~s2_reg.fx : s2_reg.fx;
        s3_next.pal_pri = attr[12:11];
        s3_next.bd      = s2_reg.bd;
        s3_next.bd_pix  = s2_reg.bd_pix;
    end

    always_comb begin
        priority if (clr_active_reg) begin
            ram_addr = clr_addr_reg;
        end else if (s2_valid_reg) begin
            ram_addr = pat_waddr;
        end else if (s_mode == tbpf_pkg::OP_WRITE) begin
            ram_addr = s_ram_address[13:2];
        end else begin
            ram_addr = nt_waddr;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic       lane_we;
        logic [7:0] lane_wd;

        assign lane_we = clr_active_reg
                       || (acc_write && (s_ram_address[1:0] == 2'(g)));
        assign lane_wd = clr_active_reg ? 8'd0 : s_ram_data;

        tbpf_ram #(
            .WIDTH (8),
            .DEPTH (tbpf_pkg::VRAM_WORDS)
        ) u_ram (
            .aclk    (aclk),
            .we      (lane_we),
            .addr    (ram_addr),
            .wr_data (lane_wd),
            .rd_data (lane_rd[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage 3: bitplanes are on the read data; pick one bit from each lane
    // ------------------------------------------------------------------
    logic [3:0] col;
    logic [5:0] pix;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            col[k] = lane_rd[k][~s3_reg.fx];
        end
        pix = s3_reg.bd ? s3_reg.bd_pix : {s3_reg.pal_pri, col};
    end

    tbpf_out_queue #(
        .WIDTH (tbpf_pkg::PIXEL_W),
        .DEPTH (OUT_DEPTH)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s3_valid_reg),
        .push_data (pix),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_pixel)
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1) begin
                clr_active_next = 1'b0;
            end
        end
        pend_next = pend_reg + PEND_W'(acc_pixel) - PEND_W'(out_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            pend_reg       <= '0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s2_valid_reg   <= acc_pixel;
            s3_valid_reg   <= s2_valid_reg;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_pixel) begin
            s2_reg <= s2_next;
        end
        if (s2_valid_reg) begin
            s3_reg <= s3_next;
        end
    end

endmodule
